>>> sv/sgld_pkg.sv
// Shared constants, codes and types for the side gap length detector.
`default_nettype none

package sgld_pkg;

    localparam int DIST_BITS         = 10;
    localparam int SPEED_BITS        = 8;
    localparam int MIN_BITS          = 10;
    localparam int IN_TIME_BITS      = 32;
    localparam int TIME_BITS_DEFAULT = 32;
    localparam int MS_PER_S          = 1000;
    localparam int LIMIT_BITS        = MIN_BITS + 10;
    localparam int SIDE_BITS         = 2;

    localparam int IN_FIELD_BITS  = 2 * DIST_BITS + IN_TIME_BITS;
    localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((SIDE_BITS + 7) / 8) * 8;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [1:0] REG_DEPTH_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_SPEED           = 2'd1;
    localparam logic [1:0] REG_MIN_SLOT_LENGTH = 2'd2;

    localparam logic [DIST_BITS-1:0]  DEPTH_RESET = 10'd50;
    localparam logic [SPEED_BITS-1:0] SPEED_RESET = 8'd20;
    localparam logic [MIN_BITS-1:0]   MIN_RESET   = 10'd40;

    localparam logic [SIDE_BITS-1:0] SIDE_NONE  = 2'd0;
    localparam logic [SIDE_BITS-1:0] SIDE_LEFT  = 2'd1;
    localparam logic [SIDE_BITS-1:0] SIDE_RIGHT = 2'd2;
    localparam logic [SIDE_BITS-1:0] SIDE_BAD   = 2'd3;

    typedef struct packed {
        logic [DIST_BITS-1:0]  depth_threshold_cm;
        logic [SPEED_BITS-1:0] speed_cm_per_s;
        logic [LIMIT_BITS-1:0] limit;
    } sgld_cfg_t;

    typedef struct packed {
        logic step;
        logic clear;
    } sgld_side_ctrl_t;

endpackage

`default_nettype wire

>>> sv/sgld_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module sgld_regs
    import sgld_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    output sgld_cfg_t                     cfg
);

    logic [DIST_BITS-1:0]  depth_reg;
    logic [SPEED_BITS-1:0] speed_reg;
    logic [MIN_BITS-1:0]   min_reg;
    logic [LIMIT_BITS-1:0] limit_reg;
    logic [1:0]            reg_index;
    logic                  wr_en;
    logic [LIMIT_BITS-1:0] limit_next;

    assign pready     = 1'b1;
    assign reg_index  = paddr[APB_ADDR_BITS-1:2];
    assign wr_en      = psel && penable && pwrite && pready;
    assign limit_next = LIMIT_BITS'(pwdata[MIN_BITS-1:0]) * LIMIT_BITS'(MS_PER_S);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= DEPTH_RESET;
            speed_reg <= SPEED_RESET;
            min_reg   <= MIN_RESET;
            limit_reg <= LIMIT_BITS'(MIN_RESET) * LIMIT_BITS'(MS_PER_S);
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_DEPTH_THRESHOLD: depth_reg <= pwdata[DIST_BITS-1:0];
                REG_SPEED:           speed_reg <= pwdata[SPEED_BITS-1:0];
                REG_MIN_SLOT_LENGTH:
                begin
                    min_reg   <= pwdata[MIN_BITS-1:0];
                    limit_reg <= limit_next;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_DEPTH_THRESHOLD: prdata = APB_DATA_BITS'(depth_reg);
            REG_SPEED:           prdata = APB_DATA_BITS'(speed_reg);
            REG_MIN_SLOT_LENGTH: prdata = APB_DATA_BITS'(min_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg.depth_threshold_cm = depth_reg;
    assign cfg.speed_cm_per_s     = speed_reg;
    assign cfg.limit              = limit_reg;

endmodule

`default_nettype wire

>>> sv/sgld_side.sv
// Gap tracker for one side: open flag, opening timestamp and held gap length.
`default_nettype none

module sgld_side
    import sgld_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sgld_side_ctrl_t      ctrl,
    input  wire logic [DIST_BITS-1:0] distance,
    input  wire logic [TIME_BITS-1:0] now,
    input  wire sgld_cfg_t            cfg,
    output logic                      over
);

    localparam int LEN_BITS = TIME_BITS + SPEED_BITS;

    logic                 open_reg;
    logic [TIME_BITS-1:0] start_reg;
    logic [LEN_BITS-1:0]  len_reg;
    logic                 is_open;
    logic                 closing;
    logic [TIME_BITS-1:0] elapsed;
    logic [LEN_BITS-1:0]  product;
    logic [LEN_BITS-1:0]  len_upd;
    logic [LEN_BITS-1:0]  len_next;

    assign is_open  = distance > cfg.depth_threshold_cm;
    assign closing  = open_reg && !is_open;
    assign elapsed  = now - start_reg;
    assign product  = LEN_BITS'(elapsed) * LEN_BITS'(cfg.speed_cm_per_s);
    assign len_upd  = closing ? product : len_reg;
    assign over     = len_upd > LEN_BITS'(cfg.limit);
    assign len_next = ctrl.clear ? '0 : len_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            start_reg <= '0;
            len_reg   <= '0;
        end
        else if (ctrl.step)
        begin
            open_reg <= is_open;
            if (is_open && !open_reg)
            begin
                start_reg <= now;
            end
            len_reg <= len_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/side_gap_length_detector.sv
// Top level of the side gap length detector: input stage, side trackers, result stage.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one sample per item: left distance, right
//   distance and a millisecond timestamp. m_tvalid/m_tready/m_tdata return
//   exactly one item per sample with the slot side (0 none, 1 left, 2 right).
//   Registers sit on the APB-style port: depth threshold at 0x0, speed at 0x4,
//   minimum slot length at 0x8; write them only while no item is in flight.
// Pipeline: the sample enters the input register at its accepting edge and the result
//   register loads when the item advances from it, which raises m_tvalid.
// Throughput: one item per cycle while m_tready stays high. Each side does its whole
//   update combinationally: TIME_BITS subtract, TIME_BITS by 8 multiply, two compares.
// Reset: clears both gap trackers, loads the register defaults (50, 20, 40)
//   and empties both stages.
// Stall: while m_tready is low the result holds, one more sample can wait in
//   the input register, and s_tready drops once both stages are full.
`default_nettype none

module side_gap_length_detector
    import sgld_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // left_distance_cm [9:0], right_distance_cm [19:10], time_ms [51:20], zero fill
    input  wire logic [IN_TDATA_BITS-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // slot_side [1:0], zero fill
    output logic      [OUT_TDATA_BITS-1:0] m_tdata,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [APB_DATA_BITS-1:0]  pwdata,
    output logic      [APB_DATA_BITS-1:0]  prdata,
    output logic                           pready
);

    sgld_cfg_t              cfg;
    sgld_side_ctrl_t        left_ctrl;
    sgld_side_ctrl_t        right_ctrl;
    logic                   left_over;
    logic                   right_over;

    logic                   in_valid_reg;
    logic [DIST_BITS-1:0]   left_reg;
    logic [DIST_BITS-1:0]   right_reg;
    logic [IN_TIME_BITS-1:0] time_reg;
    logic                   out_valid_reg;
    logic [SIDE_BITS-1:0]   side_reg;
    logic [SIDE_BITS-1:0]   side_next;
    logic [TIME_BITS-1:0]   now;
    logic                   advance;
    logic                   in_accept;

    sgld_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;
    assign now       = TIME_BITS'(time_reg);

    assign left_ctrl.step   = advance;
    assign left_ctrl.clear  = advance && left_over;
    assign right_ctrl.step  = advance;
    assign right_ctrl.clear = advance && !left_over && right_over;

    sgld_side #(.TIME_BITS(TIME_BITS)) u_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (left_ctrl),
        .distance (left_reg),
        .now      (now),
        .cfg      (cfg),
        .over     (left_over)
    );

    sgld_side #(.TIME_BITS(TIME_BITS)) u_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (right_ctrl),
        .distance (right_reg),
        .now      (now),
        .cfg      (cfg),
        .over     (right_over)
    );

    always_comb
    begin
        if (left_over)
        begin
            side_next = SIDE_LEFT;
        end
        else if (right_over)
        begin
            side_next = SIDE_RIGHT;
        end
        else
        begin
            side_next = SIDE_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            left_reg  <= s_tdata[DIST_BITS-1:0];
            right_reg <= s_tdata[2*DIST_BITS-1:DIST_BITS];
            time_reg  <= s_tdata[IN_FIELD_BITS-1:2*DIST_BITS];
        end
        if (advance)
        begin
            side_reg <= side_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_BITS'(side_reg);

    a_no_bad_side: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[SIDE_BITS-1:0] != SIDE_BAD))
        else $error("slot side code 3 on output");

    a_single_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !(left_ctrl.clear && right_ctrl.clear))
        else $error("both sides cleared by one item");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("processed item did not reach the result register");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(time_reg)))
        else $error("waiting item lost while stalled");

endmodule

`default_nettype wire
